### hdl/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg: shared constants for the LRU key-value cache
// Entry count, field widths, operation codes and the miss value.
// ----------------------------------------------------------------------------
`default_nettype none

package lkvc_pkg;

  // Number of cache entries
  localparam int ENTRIES = 16;

  // Entry index and recency rank width
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // Occupancy counter width, holds 0 to ENTRIES
  localparam int CNT_W = $clog2(ENTRIES + 1);

  // Field widths
  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;

  // Capacity register reset value
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // Operation codes
  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_STORE  = 1'b1;

  // Lookup miss result
  localparam logic [VAL_W-1:0] MISS_VALUE = {VAL_W{1'b1}};

  typedef logic [IDX_W-1:0] rank_t;
  typedef logic [KEY_W-1:0] key_t;
  typedef logic [VAL_W-1:0] val_t;

endpackage

`default_nettype wire

### hdl/lru_key_value_cache_core.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache_core: fully associative key-value cache, LRU replacement
// Lookup and store requests against a small register-based store; parallel
// key match, recency rank update and victim selection in one pass.
// ----------------------------------------------------------------------------
// An accepted request passes the input register, then the result register, on its way to out_strobe.
// Throughput: one request per cycle; busy is always low.
// The rank update and key match run combinationally between the input register and the result register.
// Reset: synchronous active-low rst_n clears valid bits, occupancy and the
// pipeline strobes; capacity returns to 16. The receiver cannot stall.
`default_nettype none

module lru_key_value_cache_core (
  input  wire                        clk,
  input  wire                        rst_n,
  // request channel
  input  wire                        start,
  output logic                       busy,
  input  wire                        in_operation,
  input  wire  [lkvc_pkg::KEY_W-1:0] in_key,
  input  wire  [lkvc_pkg::VAL_W-1:0] in_value,
  // result channel
  output logic                       out_strobe,
  output logic                       out_hit,
  output logic [lkvc_pkg::VAL_W-1:0] out_read_value,
  // configuration
  input  wire                        cfg_we,
  input  wire  [lkvc_pkg::CAP_W-1:0] cfg_wdata
);

  import lkvc_pkg::*;

  // Configuration
  logic [CAP_W-1:0] cap_r;

  // Input register
  logic             req_vld_r;
  logic             req_op_r;
  key_t             req_key_r;
  val_t             req_value_r;

  // Entry storage
  key_t             key_r   [ENTRIES];
  val_t             value_r [ENTRIES];
  rank_t            rank_r  [ENTRIES];
  rank_t            rank_nxt[ENTRIES];
  logic [ENTRIES-1:0] valid_r;
  logic [ENTRIES-1:0] valid_nxt;
  logic [ENTRIES-1:0] key_we;
  logic [ENTRIES-1:0] value_we;
  logic [CNT_W-1:0] occ_r;
  logic [CNT_W-1:0] occ_nxt;

  // Result register
  logic             out_strobe_r;
  logic             out_hit_r;
  val_t             out_read_value_r;
  logic             hit_nxt;
  val_t             read_value_nxt;

  // Match and replacement logic
  logic [ENTRIES-1:0] hit_vec;
  logic [ENTRIES-1:0] victim_vec;
  logic [ENTRIES-1:0] valid_after;
  logic             hit;
  rank_t            hit_rank;
  val_t             hit_data;
  logic [CNT_W-1:0] eff_cap;
  rank_t            oldest_rank;
  logic             evict;
  logic             fill_any;
  rank_t            fill_idx;

  assign busy = 1'b0;

  // Hold the capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
    end else begin
      req_vld_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      req_op_r    <= in_operation;
      req_key_r   <= in_key;
      req_value_r <= in_value;
    end
  end

  // Clamp the capacity to 1..ENTRIES
  always_comb begin
    if (cap_r == '0) begin
      eff_cap = CNT_W'(1);
    end else if (int'(cap_r) > ENTRIES) begin
      eff_cap = CNT_W'(ENTRIES);
    end else begin
      eff_cap = CNT_W'(cap_r);
    end
  end

  // Match keys, select the victim and the free slot
  always_comb begin
    hit_rank    = '0;
    hit_data    = '0;
    oldest_rank = IDX_W'(occ_r - CNT_W'(1));
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i]    = valid_r[i] && (key_r[i] == req_key_r);
      victim_vec[i] = valid_r[i] && (rank_r[i] == oldest_rank);
      hit_rank      = hit_rank | (rank_r[i] & {IDX_W{hit_vec[i]}});
      hit_data      = hit_data | (value_r[i] & {VAL_W{hit_vec[i]}});
    end
    hit         = |hit_vec;
    evict       = (req_op_r == OP_STORE) && !hit && (occ_r >= eff_cap);
    valid_after = valid_r & ~(victim_vec & {ENTRIES{evict}});
    fill_any    = 1'b0;
    fill_idx    = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_after[i]) begin
        fill_any = 1'b1;
        fill_idx = IDX_W'(i);
      end
    end
  end

  // Work out the next state and the result
  always_comb begin
    valid_nxt      = valid_r;
    occ_nxt        = occ_r;
    key_we         = '0;
    value_we       = '0;
    hit_nxt        = hit;
    read_value_nxt = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      rank_nxt[i] = rank_r[i];
    end
    if (req_op_r == OP_LOOKUP) begin
      read_value_nxt = hit ? hit_data : MISS_VALUE;
    end
    if (req_vld_r) begin
      if (hit) begin
        // Move the matched entry to the front, age the more recent ones
        for (int i = 0; i < ENTRIES; i++) begin
          if (hit_vec[i]) begin
            rank_nxt[i] = '0;
            value_we[i] = (req_op_r == OP_STORE);
          end else if (valid_r[i] && (rank_r[i] < hit_rank)) begin
            rank_nxt[i] = rank_r[i] + IDX_W'(1);
          end
        end
      end else if (req_op_r == OP_STORE && fill_any) begin
        // Drop the victim, age all survivors, insert at the front
        valid_nxt = valid_after;
        for (int i = 0; i < ENTRIES; i++) begin
          if (IDX_W'(i) == fill_idx) begin
            valid_nxt[i] = 1'b1;
            rank_nxt[i]  = '0;
            key_we[i]    = 1'b1;
            value_we[i]  = 1'b1;
          end else if (valid_after[i]) begin
            rank_nxt[i] = rank_r[i] + IDX_W'(1);
          end
        end
        if (!evict) begin
          occ_nxt = occ_r + CNT_W'(1);
        end
      end
    end
  end

  // Update entry control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      occ_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      occ_r   <= occ_nxt;
    end
  end

  // Update entry payload
  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      rank_r[i] <= rank_nxt[i];
      if (key_we[i]) begin
        key_r[i] <= req_key_r;
      end
      if (value_we[i]) begin
        value_r[i] <= req_value_r;
      end
    end
  end

  // Register the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= req_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (req_vld_r) begin
      out_hit_r        <= hit_nxt;
      out_read_value_r <= read_value_nxt;
    end
  end

  assign out_strobe     = out_strobe_r;
  assign out_hit        = out_hit_r;
  assign out_read_value = out_read_value_r;

endmodule

`default_nettype wire

### test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: regression bench for lru_key_value_cache_core
// Sends lookup and store requests, mirrors the LRU store in a scoreboard class
// and compares every hit flag and read value. The capacity register is moved
// through small, large, zero and oversized settings between request phases.
// ----------------------------------------------------------------------------

module tb;
  import lkvc_pkg::*;

  // One result as the block reports it
  typedef struct {
    logic hit;
    val_t read_value;
  } lookup_reply_t;

  // Mirror of the cache contents; predicts the reply of each request
  class lru_mirror;
    key_t             slot_key  [ENTRIES];
    val_t             slot_val  [ENTRIES];
    bit               slot_live [ENTRIES];
    int unsigned      slot_age  [ENTRIES];
    int unsigned      fill;
    logic [CAP_W-1:0] cap_reg;
    lookup_reply_t    replies[$];
    int unsigned      requests, hits, evictions, checked, errors;

    function void clear();
      fill = 0;
      cap_reg = CAP_RESET;
      foreach (slot_live[i]) begin
        slot_live[i] = 1'b0;
        slot_age[i] = 0;
      end
      replies.delete();
    endfunction

    function void set_capacity(logic [CAP_W-1:0] c);
      cap_reg = c;
    endfunction

    // Zero behaves as one; values above the entry count saturate
    function int unsigned limit();
      int unsigned c;
      c = cap_reg;
      if (c == 0) c = 1;
      if (c > ENTRIES) c = ENTRIES;
      return c;
    endfunction

    function int find(key_t k);
      for (int i = 0; i < ENTRIES; i++)
        if (slot_live[i] && slot_key[i] == k) return i;
      return -1;
    endfunction

    function int free_slot();
      for (int i = 0; i < ENTRIES; i++)
        if (!slot_live[i]) return i;
      return -1;
    endfunction

    // Make slot s the most recent; younger entries age by one
    function void promote(int s);
      int unsigned r;
      r = slot_age[s];
      for (int i = 0; i < ENTRIES; i++)
        if (slot_live[i] && slot_age[i] < r) slot_age[i]++;
      slot_age[s] = 0;
    endfunction

    function void drop_oldest();
      int          victim;
      int unsigned oldest;
      victim = -1;
      oldest = 0;
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_live[i] && (victim < 0 || slot_age[i] > oldest)) begin
          victim = i;
          oldest = slot_age[i];
        end
      end
      if (victim >= 0) begin
        slot_live[victim] = 1'b0;
        if (fill > 0) fill--;
        evictions++;
      end
    endfunction

    // Note an accepted request and queue the reply it must produce
    function void apply_request(logic op, key_t k, val_t v);
      int            s;
      lookup_reply_t r;
      requests++;
      s = find(k);
      r.hit = (s >= 0);
      r.read_value = '0;
      if (s >= 0) hits++;
      if (op == OP_LOOKUP) begin
        if (s >= 0) begin
          r.read_value = slot_val[s];
          promote(s);
        end else begin
          r.read_value = MISS_VALUE;
        end
      end else if (s >= 0) begin
        slot_val[s] = v;
        promote(s);
      end else begin
        // Make room first, even when capacity was lowered below the fill
        if (fill >= limit()) drop_oldest();
        s = free_slot();
        if (s < 0) begin
          drop_oldest();
          s = free_slot();
        end
        if (s >= 0) begin
          for (int i = 0; i < ENTRIES; i++)
            if (slot_live[i]) slot_age[i]++;
          slot_key[s] = k;
          slot_val[s] = v;
          slot_live[s] = 1'b1;
          slot_age[s] = 0;
          fill++;
        end
      end
      replies.push_back(r);
    endfunction

    function void report(string what);
      errors++;
      if (errors <= 10) $display("[%0t] MISMATCH %s", $realtime, what);
    endfunction

    // Compare one result against the oldest queued reply
    function void compare_reply(logic hit, val_t rv);
      lookup_reply_t e;
      if (replies.size() == 0) begin
        report($sformatf("result with nothing pending: hit=%0b value=%h", hit, rv));
        return;
      end
      e = replies.pop_front();
      checked++;
      if (hit !== e.hit)
        report($sformatf("hit: expected %0b, got %0b", e.hit, hit));
      if (rv !== e.read_value)
        report($sformatf("read_value: expected %h, got %h", e.read_value, rv));
    endfunction

    function int unsigned pending();
      return replies.size();
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic             in_operation;
  key_t             in_key;
  val_t             in_value;
  logic             out_strobe;
  logic             out_hit;
  val_t             out_read_value;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_wdata;

  lru_mirror   mirror = new();
  int unsigned cap_writes;

  lru_key_value_cache_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_operation   (in_operation),
    .in_key         (in_key),
    .in_value       (in_value),
    .out_strobe     (out_strobe),
    .out_hit        (out_hit),
    .out_read_value (out_read_value),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("lru_key_value_cache_core regression: fail");
    $finish;
  end

  // Watch both channels; note the request before checking any result
  always @(posedge clk) begin
    if (rst_n === 1'b1 && start && busy === 1'b0)
      mirror.apply_request(in_operation, in_key, in_value);
    if (rst_n === 1'b1 && out_strobe === 1'b1)
      mirror.compare_reply(out_hit, out_read_value);
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Present one request and hold it until accepted
  task automatic issue_request(logic op, key_t k, val_t v, int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_operation <= op;
    in_key <= k;
    in_value <= v;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  // Drop start and wait until every reply is back
  task automatic settle();
    start <= 1'b0;
    while (mirror.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] c);
    cfg_we <= 1'b1;
    cfg_wdata <= c;
    @(posedge clk);
    cfg_we <= 1'b0;
    mirror.set_capacity(c);
    cap_writes++;
    @(posedge clk);
  endtask

  // Random traffic over a small key set sized to the capacity
  task automatic run_phase(logic [CAP_W-1:0] cap, int unsigned count);
    key_t        pool [24];
    int unsigned span;
    bit          burst;
    logic        op;
    key_t        k;
    val_t        v;
    settle();
    write_capacity(cap);
    foreach (pool[i]) pool[i] = $urandom;
    if ($urandom_range(0, 1)) pool[0] = '0;
    if ($urandom_range(0, 1)) pool[1] = '1;
    span = (cap == 0) ? 1 : (cap > ENTRIES) ? ENTRIES : cap;
    span = span + 4;
    burst = 1'b0;
    for (int n = 0; n < count; n++) begin
      if (n % 48 == 0) burst = ($urandom_range(0, 3) == 0);
      op = $urandom_range(0, 1) ? OP_STORE : OP_LOOKUP;
      if ($urandom_range(0, 99) < 85) k = pool[$urandom_range(0, span - 1)];
      else k = $urandom;
      case ($urandom_range(0, 9))
        0: v = '0;
        1: v = '1;
        2: v = {1'b1, {(VAL_W-1){1'b0}}};
        3: v = {1'b0, {(VAL_W-1){1'b1}}};
        default: v = $urandom;
      endcase
      issue_request(op, k, v, burst ? 0 : pick_gap());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_operation = OP_LOOKUP;
    in_key = '0;
    in_value = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    cap_writes = 0;
    mirror.clear();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty cache miss, extreme keys and values, overwrite on hit
    issue_request(OP_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF, pick_gap());
    issue_request(OP_STORE,  32'h8000_0000, 32'h7FFF_FFFF, pick_gap());
    issue_request(OP_STORE,  32'h7FFF_FFFF, 32'h8000_0000, pick_gap());
    issue_request(OP_STORE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, pick_gap());
    issue_request(OP_STORE,  32'h0000_0000, 32'h0000_0000, pick_gap());
    issue_request(OP_LOOKUP, 32'h8000_0000, 32'h0000_0000, pick_gap());
    issue_request(OP_LOOKUP, 32'h7FFF_FFFF, 32'h5555_5555, pick_gap());
    // stored value equals the miss value, but hit is set
    issue_request(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, pick_gap());
    issue_request(OP_LOOKUP, 32'h0000_0000, 32'hAAAA_AAAA, pick_gap());
    issue_request(OP_STORE,  32'h8000_0000, 32'h1234_5678, pick_gap());
    issue_request(OP_LOOKUP, 32'h8000_0000, 32'h0000_0000, pick_gap());
    issue_request(OP_LOOKUP, 32'h0000_0001, 32'h0000_0000, pick_gap());

    // Capacity lowered below the current fill: store misses evict one each
    settle();
    write_capacity(CAP_W'(2));
    issue_request(OP_STORE,  32'hA5A5_A5A5, 32'h0000_0001, pick_gap());
    issue_request(OP_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000, pick_gap());
    issue_request(OP_STORE,  32'h5A5A_5A5A, 32'h0000_0002, pick_gap());
    issue_request(OP_LOOKUP, 32'hA5A5_A5A5, 32'h0000_0000, pick_gap());

    // Zero capacity acts as one
    settle();
    write_capacity(CAP_W'(0));
    issue_request(OP_STORE,  32'h1111_1111, 32'h0000_0003, pick_gap());
    issue_request(OP_LOOKUP, 32'h1111_1111, 32'h0000_0000, pick_gap());

    // Oversized capacity saturates at the entry count
    settle();
    write_capacity(CAP_W'(31));
    issue_request(OP_STORE,  32'h2222_2222, 32'h0000_0004, pick_gap());
    issue_request(OP_STORE,  32'h3333_3333, 32'h0000_0005, pick_gap());
    issue_request(OP_LOOKUP, 32'h2222_2222, 32'h0000_0000, pick_gap());
    issue_request(OP_LOOKUP, 32'h1111_1111, 32'h0000_0000, pick_gap());

    // Random phases; a full cache is followed by a lowered capacity
    run_phase(CAP_W'(16), 170);
    run_phase(CAP_W'(1),  170);
    run_phase(CAP_W'(3),  170);
    run_phase(CAP_W'(0),  120);
    run_phase(CAP_W'(8),  170);
    run_phase(CAP_W'(31), 170);
    run_phase(CAP_W'(16), 190);
    run_phase(CAP_W'(5),  170);
    run_phase(CAP_W'(2),  170);
    run_phase(CAP_W'(12), 170);
    run_phase(CAP_W'(16), 170);

    // Drain with a bound, then let the pipeline go quiet
    start <= 1'b0;
    for (int n = 0; n < 200 && mirror.pending() != 0; n++) @(posedge clk);
    repeat (6) @(posedge clk);
    if (mirror.pending() != 0)
      mirror.report($sformatf("%0d replies never arrived", mirror.pending()));

    $display("Covered %0d requests (%0d hits, %0d evictions) over %0d capacity writes.",
             mirror.requests, mirror.hits, mirror.evictions, cap_writes);
    $display("Checked %0d results, %0d mismatches.", mirror.checked, mirror.errors);
    if (mirror.errors == 0) begin
      $display("lru_key_value_cache_core regression: pass");
    end else begin
      $display("lru_key_value_cache_core regression: fail");
    end
    $finish;
  end

endmodule
